>>> src/nmea_rmc_position_parser_core_assert.svh
// Assertion macros shared by the NMEA RMC position parser modules.
`ifndef NMEA_RMC_POSITION_PARSER_CORE_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define NRP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define NRP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define NRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nrp_pkg.sv
// Shared types, constants and helper functions of the NMEA RMC position parser.
`timescale 1ns / 1ps
`default_nettype none

package nrp_pkg;

    // Default build values.
    localparam int MAX_SENTENCE_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH_DEF        = 2;

    // Field widths.
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int MIN_W     = 20;
    localparam int LAT_OUT_W = 27;
    localparam int LON_OUT_W = 30;
    localparam int M5_W      = 23;
    localparam int Q_W       = 21;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FIX    = 2'd1;
    localparam logic [1:0] STATUS_BAD_COORD = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_FIX_OK  = 8'h41;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Offsets after the dollar sign.
    localparam int HEADER_LEN    = 5;
    localparam int POS_FIX       = 17;
    localparam int POS_LAT_FIRST = 19;
    localparam int POS_LAT_MIN   = 21;
    localparam int POS_LAT_DOT   = 23;
    localparam int POS_LAT_LAST  = 27;
    localparam int POS_NS        = 29;
    localparam int POS_LON_FIRST = 31;
    localparam int POS_LON_MIN   = 34;
    localparam int POS_LON_DOT   = 36;
    localparam int POS_LON_LAST  = 40;
    localparam int POS_EW        = 42;

    // Conversion constants: minutes_e4 * 5 / 3 by reciprocal multiplication.
    localparam int MICRO_PER_DEG = 1000000;
    localparam int DIV3_SHIFT    = 25;
    localparam int DIV3_MULT     = (1 << DIV3_SHIFT) / 3 + 1;
    localparam int DIV3_MULT_W   = 24;
    localparam int DIV3_PROD_W   = M5_W + DIV3_MULT_W;

    // One finished sentence handed from the front to the back.
    typedef struct packed {
        logic [1:0]           status;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
        logic [7:0]           ns;
        logic [7:0]           ew;
    } t_sentence;

    // Expected header character at a header offset.
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4D;
            3'd4:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/nrp_front.sv
// Front end: frames sentences byte by byte and gathers fix and coordinate fields.
`timescale 1ns / 1ps
`default_nettype none

module nrp_front #(
    parameter int MAX_SENTENCE_BYTES = nrp_pkg::MAX_SENTENCE_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_q_ready,
    output logic                    o_push,
    output nrp_pkg::t_sentence      o_rec
);

    localparam int PW = $clog2(MAX_SENTENCE_BYTES + 1);

    localparam logic [PW-1:0] P_HDR_LEN   = PW'(nrp_pkg::HEADER_LEN);
    localparam logic [PW-1:0] P_MAX       = PW'(MAX_SENTENCE_BYTES);
    localparam logic [PW-1:0] P_FIX       = PW'(nrp_pkg::POS_FIX);
    localparam logic [PW-1:0] P_LAT_FIRST = PW'(nrp_pkg::POS_LAT_FIRST);
    localparam logic [PW-1:0] P_LAT_MIN   = PW'(nrp_pkg::POS_LAT_MIN);
    localparam logic [PW-1:0] P_LAT_DOT   = PW'(nrp_pkg::POS_LAT_DOT);
    localparam logic [PW-1:0] P_LAT_LAST  = PW'(nrp_pkg::POS_LAT_LAST);
    localparam logic [PW-1:0] P_NS        = PW'(nrp_pkg::POS_NS);
    localparam logic [PW-1:0] P_LON_FIRST = PW'(nrp_pkg::POS_LON_FIRST);
    localparam logic [PW-1:0] P_LON_MIN   = PW'(nrp_pkg::POS_LON_MIN);
    localparam logic [PW-1:0] P_LON_DOT   = PW'(nrp_pkg::POS_LON_DOT);
    localparam logic [PW-1:0] P_LON_LAST  = PW'(nrp_pkg::POS_LON_LAST);
    localparam logic [PW-1:0] P_EW        = PW'(nrp_pkg::POS_EW);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } t_phase;

    t_phase                            r_phase;
    logic [PW-1:0]                     r_pos;
    logic                              r_header_ok;
    logic [7:0]                        r_fix;
    logic [nrp_pkg::LAT_DEG_W-1:0]     r_lat_deg;
    logic [nrp_pkg::MIN_W-1:0]         r_lat_min;
    logic [nrp_pkg::LON_DEG_W-1:0]     r_lon_deg;
    logic [nrp_pkg::MIN_W-1:0]         r_lon_min;
    logic [7:0]                        r_ns;
    logic [7:0]                        r_ew;
    logic                              r_digit_err;

    logic                              w_accept;
    logic                              w_is_digit;
    logic [3:0]                        w_digit;
    logic                              w_in_lat;
    logic                              w_in_lon;
    logic                              w_body_live;
    logic [1:0]                        w_status;
    logic [nrp_pkg::LAT_DEG_W-1:0]     w_lat_deg_acc;
    logic [nrp_pkg::MIN_W-1:0]         w_lat_min_acc;
    logic [nrp_pkg::LON_DEG_W-1:0]     w_lon_deg_acc;
    logic [nrp_pkg::MIN_W-1:0]         w_lon_min_acc;

    // A byte is taken whenever the queue can hold a possible result.
    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;

    // Digit decode and the decimal accumulators, wrapping at their widths.
    assign w_is_digit    = (i_rx_byte >= nrp_pkg::CHAR_ZERO) && (i_rx_byte <= nrp_pkg::CHAR_NINE);
    assign w_digit       = i_rx_byte[3:0];
    assign w_lat_deg_acc = nrp_pkg::LAT_DEG_W'(r_lat_deg * 7'd10 + 7'(w_digit));
    assign w_lat_min_acc = nrp_pkg::MIN_W'(r_lat_min * 20'd10 + 20'(w_digit));
    assign w_lon_deg_acc = nrp_pkg::LON_DEG_W'(r_lon_deg * 10'd10 + 10'(w_digit));
    assign w_lon_min_acc = nrp_pkg::MIN_W'(r_lon_min * 20'd10 + 20'(w_digit));

    // Coordinate digit windows, dots excluded.
    assign w_in_lat = (r_pos >= P_LAT_FIRST) && (r_pos <= P_LAT_LAST) && (r_pos != P_LAT_DOT);
    assign w_in_lon = (r_pos >= P_LON_FIRST) && (r_pos <= P_LON_LAST) && (r_pos != P_LON_DOT);

    // A body byte that still counts towards the sentence.
    assign w_body_live = (i_rx_byte != nrp_pkg::CHAR_DOLLAR) && (r_phase == PH_BODY)
                         && r_header_ok && (r_pos < P_MAX);

    // Status of the sentence that a newline would close now.
    always_comb begin
        if (r_fix != nrp_pkg::CHAR_FIX_OK) begin
            w_status = nrp_pkg::STATUS_NO_FIX;
        end else if (r_digit_err || (r_pos <= P_LON_LAST)) begin
            w_status = nrp_pkg::STATUS_BAD_COORD;
        end else begin
            w_status = nrp_pkg::STATUS_OK;
        end
    end

    // Result request towards the queue; the fields are zero unless the status is OK.
    assign o_push = w_accept && w_body_live && (i_rx_byte == nrp_pkg::CHAR_NEWLINE);

    always_comb begin
        o_rec        = '0;
        o_rec.status = w_status;
        if (w_status == nrp_pkg::STATUS_OK) begin
            o_rec.lat_deg = r_lat_deg;
            o_rec.lat_min = r_lat_min;
            o_rec.lon_deg = r_lon_deg;
            o_rec.lon_min = r_lon_min;
            o_rec.ns      = r_ns;
            o_rec.ew      = r_ew;
        end
    end

    // Framing state machine and field capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_header_ok <= 1'b0;
            r_fix       <= '0;
            r_lat_deg   <= '0;
            r_lat_min   <= '0;
            r_lon_deg   <= '0;
            r_lon_min   <= '0;
            r_ns        <= '0;
            r_ew        <= '0;
            r_digit_err <= 1'b0;
        end else if (w_accept) begin
            if (i_rx_byte == nrp_pkg::CHAR_DOLLAR) begin
                r_phase     <= PH_HEADER;
                r_pos       <= '0;
                r_header_ok <= 1'b0;
                r_fix       <= '0;
                r_lat_deg   <= '0;
                r_lat_min   <= '0;
                r_lon_deg   <= '0;
                r_lon_min   <= '0;
                r_ns        <= '0;
                r_ew        <= '0;
                r_digit_err <= 1'b0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if ((r_pos >= P_HDR_LEN)
                            || (i_rx_byte != nrp_pkg::header_char(r_pos[2:0]))) begin
                            r_phase <= PH_IDLE;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                            if ((r_pos + 1'b1) == P_HDR_LEN) begin
                                r_header_ok <= 1'b1;
                                r_phase     <= PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (!w_body_live || (i_rx_byte == nrp_pkg::CHAR_NEWLINE)) begin
                            r_phase <= PH_IDLE;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                            if (r_pos == P_FIX) begin
                                r_fix <= i_rx_byte;
                            end else if (r_pos == P_NS) begin
                                r_ns <= i_rx_byte;
                            end else if (r_pos == P_EW) begin
                                r_ew <= i_rx_byte;
                            end else if (w_in_lat) begin
                                if (!w_is_digit) begin
                                    r_digit_err <= 1'b1;
                                end else if (r_pos < P_LAT_MIN) begin
                                    r_lat_deg <= w_lat_deg_acc;
                                end else begin
                                    r_lat_min <= w_lat_min_acc;
                                end
                            end else if (w_in_lon) begin
                                if (!w_is_digit) begin
                                    r_digit_err <= 1'b1;
                                end else if (r_pos < P_LON_MIN) begin
                                    r_lon_deg <= w_lon_deg_acc;
                                end else begin
                                    r_lon_min <= w_lon_min_acc;
                                end
                            end
                        end
                    end
                    default: begin
                        r_phase <= PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> src/nrp_queue.sv
// Short register queue of finished sentences between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module nrp_queue #(
    parameter int QUEUE_DEPTH = nrp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire nrp_pkg::t_sentence i_rec,
    output logic                    o_push_ready,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output nrp_pkg::t_sentence      o_rec
);

`include "nmea_rmc_position_parser_core_assert.svh"

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    nrp_pkg::t_sentence r_slot [QUEUE_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic               w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_valid      = (r_count != '0);
    assign o_rec        = r_slot[r_rd_ptr];
    assign w_pop        = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

    // The fill count never passes the depth.
    `NRP_ASSERT_ALWAYS(a_count_bound, r_count <= FULL_CNT, "queue count exceeds depth")
    // A push without a pop grows the count by one.
    `NRP_ASSERT_NEXT(a_count_grow, i_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow")
    // A push into an empty queue shows up at the head next cycle.
    `NRP_ASSERT_NEXT(a_head_fill, i_push && (r_count == '0), o_valid && (o_rec == $past(i_rec)), "queue head lost a request")

endmodule

`default_nettype wire

>>> src/nrp_back.sv
// Back end: converts degrees and minutes to micro-degrees in a three-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

module nrp_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire nrp_pkg::t_sentence                  i_rec,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [1:0]                               o_status,
    output logic [nrp_pkg::LAT_OUT_W-1:0]            o_latitude_micro_deg,
    output logic [nrp_pkg::LON_OUT_W-1:0]            o_longitude_micro_deg,
    output logic [7:0]                               o_lat_hemisphere,
    output logic [7:0]                               o_lon_hemisphere
);

`include "nmea_rmc_position_parser_core_assert.svh"

    typedef struct packed {
        logic [1:0]                      status;
        logic [7:0]                      ns;
        logic [7:0]                      ew;
        logic [nrp_pkg::LAT_OUT_W-1:0]   lat_dp;
        logic [nrp_pkg::LON_OUT_W-1:0]   lon_dp;
        logic [nrp_pkg::M5_W-1:0]        lat_m5;
        logic [nrp_pkg::M5_W-1:0]        lon_m5;
    } t_stage1;

    typedef struct packed {
        logic [1:0]                      status;
        logic [7:0]                      ns;
        logic [7:0]                      ew;
        logic [nrp_pkg::LAT_OUT_W-1:0]   lat_dp;
        logic [nrp_pkg::LON_OUT_W-1:0]   lon_dp;
        logic [nrp_pkg::Q_W-1:0]         lat_q;
        logic [nrp_pkg::Q_W-1:0]         lon_q;
    } t_stage2;

    logic     r_s1_valid;
    logic     r_s2_valid;
    logic     r_s3_valid;
    t_stage1  r_s1;
    t_stage2  r_s2;
    t_stage1  n_s1;
    t_stage2  n_s2;
    logic     w_adv1;
    logic     w_adv2;
    logic     w_adv3;
    logic     w_pop;
    logic     w_fields_zero;
    logic [nrp_pkg::DIV3_PROD_W-1:0] w_lat_prod;
    logic [nrp_pkg::DIV3_PROD_W-1:0] w_lon_prod;

    // Each stage moves on when the one after it is empty or moving.
    assign w_adv3  = !r_s3_valid || i_out_ready;
    assign w_adv2  = !r_s2_valid || w_adv3;
    assign w_adv1  = !r_s1_valid || w_adv2;
    assign o_ready = w_adv1;
    assign w_pop   = i_valid && w_adv1;

    // Stage one: degrees times one million, minutes times five.
    always_comb begin
        n_s1.status = i_rec.status;
        n_s1.ns     = i_rec.ns;
        n_s1.ew     = i_rec.ew;
        n_s1.lat_dp = nrp_pkg::LAT_OUT_W'(i_rec.lat_deg)
                      * nrp_pkg::LAT_OUT_W'(nrp_pkg::MICRO_PER_DEG);
        n_s1.lon_dp = nrp_pkg::LON_OUT_W'(i_rec.lon_deg)
                      * nrp_pkg::LON_OUT_W'(nrp_pkg::MICRO_PER_DEG);
        n_s1.lat_m5 = nrp_pkg::M5_W'({i_rec.lat_min, 2'b00}) + nrp_pkg::M5_W'(i_rec.lat_min);
        n_s1.lon_m5 = nrp_pkg::M5_W'({i_rec.lon_min, 2'b00}) + nrp_pkg::M5_W'(i_rec.lon_min);
    end

    // Stage two: division by three through the reciprocal.
    assign w_lat_prod = nrp_pkg::DIV3_PROD_W'(r_s1.lat_m5)
                        * nrp_pkg::DIV3_PROD_W'(nrp_pkg::DIV3_MULT);
    assign w_lon_prod = nrp_pkg::DIV3_PROD_W'(r_s1.lon_m5)
                        * nrp_pkg::DIV3_PROD_W'(nrp_pkg::DIV3_MULT);

    always_comb begin
        n_s2.status = r_s1.status;
        n_s2.ns     = r_s1.ns;
        n_s2.ew     = r_s1.ew;
        n_s2.lat_dp = r_s1.lat_dp;
        n_s2.lon_dp = r_s1.lon_dp;
        n_s2.lat_q  = nrp_pkg::Q_W'(w_lat_prod >> nrp_pkg::DIV3_SHIFT);
        n_s2.lon_q  = nrp_pkg::Q_W'(w_lon_prod >> nrp_pkg::DIV3_SHIFT);
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Stage payloads; stage three is the output register.
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1 <= n_s1;
        end
        if (w_adv2) begin
            r_s2 <= n_s2;
        end
        if (w_adv3) begin
            o_status              <= r_s2.status;
            o_lat_hemisphere      <= r_s2.ns;
            o_lon_hemisphere      <= r_s2.ew;
            o_latitude_micro_deg  <= r_s2.lat_dp + nrp_pkg::LAT_OUT_W'(r_s2.lat_q);
            o_longitude_micro_deg <= r_s2.lon_dp + nrp_pkg::LON_OUT_W'(r_s2.lon_q);
        end
    end

    assign o_out_valid = r_s3_valid;

    // All result fields of the output register are zero.
    assign w_fields_zero = (o_latitude_micro_deg == '0) && (o_longitude_micro_deg == '0)
                           && (o_lat_hemisphere == '0) && (o_lon_hemisphere == '0);

    // A result whose status is not OK carries only zero fields.
    `NRP_ASSERT_IMP(a_zero_on_error, r_s3_valid && (o_status != nrp_pkg::STATUS_OK), w_fields_zero, "non-zero fields")
    // A request taken from the queue lands in stage one.
    `NRP_ASSERT_NEXT(a_pop_lands, w_pop, r_s1_valid, "popped request lost")
    // A stalled middle stage keeps its contents.
    `NRP_ASSERT_NEXT(a_s2_hold, r_s2_valid && !w_adv2, r_s2_valid && $stable(r_s2), "stalled stage changed")

endmodule

`default_nettype wire

>>> src/nmea_rmc_position_parser_core.sv
// Top level of the NMEA RMC position parser: framing front, result queue, conversion back.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_ready   i_rx_byte
//   output   out        o_out_valid / i_out_ready o_status, o_latitude_micro_deg,
//                                                 o_longitude_micro_deg,
//                                                 o_lat_hemisphere, o_lon_hemisphere
//
// One byte is taken every cycle while the result queue has room.
// A result goes from its newline through the queue, then stage one, stage two and the
// output register; the pipeline's divide-by-three multiplier sets the stage split.
// Reset is synchronous and active low; no clearing pass follows it.
// When results are not taken the pipeline fills, then the queue, and only then
// does o_in_ready fall.
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_position_parser_core #(
    parameter int MAX_SENTENCE_BYTES = nrp_pkg::MAX_SENTENCE_BYTES_DEF,
    parameter int QUEUE_DEPTH        = nrp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_status,
    output logic [nrp_pkg::LAT_OUT_W-1:0]       o_latitude_micro_deg,
    output logic [nrp_pkg::LON_OUT_W-1:0]       o_longitude_micro_deg,
    output logic [7:0]                          o_lat_hemisphere,
    output logic [7:0]                          o_lon_hemisphere
);

    logic               w_push;
    logic               w_push_ready;
    nrp_pkg::t_sentence w_front_rec;
    logic               w_q_valid;
    logic               w_q_ready;
    nrp_pkg::t_sentence w_q_rec;

    // Sentence framing and field capture.
    nrp_front #(
        .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_ready  (w_push_ready),
        .o_push     (w_push),
        .o_rec      (w_front_rec)
    );

    // Decoupling queue.
    nrp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_rec        (w_front_rec),
        .o_push_ready (w_push_ready),
        .o_valid      (w_q_valid),
        .i_ready      (w_q_ready),
        .o_rec        (w_q_rec)
    );

    // Coordinate conversion and output register.
    nrp_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (w_q_valid),
        .o_ready               (w_q_ready),
        .i_rec                 (w_q_rec),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_status              (o_status),
        .o_latitude_micro_deg  (o_latitude_micro_deg),
        .o_longitude_micro_deg (o_longitude_micro_deg),
        .o_lat_hemisphere      (o_lat_hemisphere),
        .o_lon_hemisphere      (o_lon_hemisphere)
    );

endmodule

`default_nettype wire

>>> test/nmea_rmc_position_parser_core_test.sv
// Self-checking testbench of the NMEA RMC position parser core, driven byte by byte.
`timescale 1ns / 1ps

module nmea_rmc_position_parser_core_test;
    import nrp_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_BYTES   = 100;
    localparam int RANDOM_REPORTS = 2;
    localparam int SENTENCE_LIMIT = MAX_SENTENCE_BYTES_DEF;

    localparam int unsigned LAT_DEG_MASK = (1 << LAT_DEG_W) - 1;
    localparam int unsigned LON_DEG_MASK = (1 << LON_DEG_W) - 1;
    localparam int unsigned MIN_MASK     = (1 << MIN_W) - 1;

    localparam logic [39:0] RMC_TAG    = "GPRMC";
    localparam logic [7:0]  CH_COMMA   = ",";
    localparam logic [7:0]  CH_DOT     = ".";
    localparam logic [7:0]  CH_NORTH   = "N";
    localparam logic [7:0]  CH_SOUTH   = "S";
    localparam logic [7:0]  CH_EAST    = "E";
    localparam logic [7:0]  CH_WEST    = "W";
    localparam logic [7:0]  CH_VOID    = "V";
    localparam logic [7:0]  CH_FIVE    = "5";
    localparam logic [7:0]  CH_LETTER  = "x";
    localparam logic [7:0]  CH_BAD_TAG = "X";
    localparam logic [7:0]  CH_LOWER_Z = "z";

    typedef enum logic [1:0] {FRAME_IDLE, FRAME_HEADER, FRAME_BODY} frame_e;
    typedef enum logic [1:0] {SINK_ALWAYS, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_mode_e;
    typedef enum logic [2:0] {
        LINE_GOOD, LINE_NO_FIX, LINE_BAD_DIGIT, LINE_SHORT,
        LINE_LONG, LINE_BAD_TAG, LINE_RESTART, LINE_NOISE
    } line_kind_e;

    typedef struct packed {
        logic [1:0]           status;
        logic [LAT_OUT_W-1:0] lat;
        logic [LON_OUT_W-1:0] lon;
        logic [7:0]           ns;
        logic [7:0]           ew;
    } fix_report_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_rx_byte   = 8'h00;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic [LAT_OUT_W-1:0] o_latitude_micro_deg;
    logic [LON_OUT_W-1:0] o_longitude_micro_deg;
    logic [7:0]           o_lat_hemisphere;
    logic [7:0]           o_lon_hemisphere;

    // Parser state as predicted from the accepted bytes.
    frame_e      frame;
    int unsigned offset;
    logic        tag_done;
    logic [7:0]  fix_byte;
    int unsigned lat_whole;
    int unsigned lat_frac;
    int unsigned lon_whole;
    int unsigned lon_frac;
    logic [7:0]  ns_byte;
    logic [7:0]  ew_byte;
    logic        coord_fault;

    fix_report_t pending_reports[$];
    logic [7:0]  line_buf[$];
    string       trail_text = ",0.5,54.7,191194,020.3,E*68\r";

    int unsigned fail_count;
    int unsigned reports_checked;
    int unsigned reports_predicted;
    int unsigned framed_bytes;
    int unsigned input_stalls;
    int unsigned cycle_count;
    int unsigned burst_left;
    bit          sender_gaps = 1'b1;

    bit          hold_request;
    int unsigned hold_left;
    sink_mode_e  sink_mode;
    int unsigned sink_left;
    int unsigned sink_period;
    int unsigned sink_duty;
    int unsigned sink_tick;

    nmea_rmc_position_parser_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_rx_byte             (i_rx_byte),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_status              (o_status),
        .o_latitude_micro_deg  (o_latitude_micro_deg),
        .o_longitude_micro_deg (o_longitude_micro_deg),
        .o_lat_hemisphere      (o_lat_hemisphere),
        .o_lon_hemisphere      (o_lon_hemisphere)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d reports outstanding.",
                     cycle_count, pending_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    // Sentence prediction.

    function automatic void forget_sentence();
        offset      = 0;
        tag_done    = 1'b0;
        fix_byte    = 8'h00;
        lat_whole   = 0;
        lat_frac    = 0;
        lon_whole   = 0;
        lon_frac    = 0;
        ns_byte     = 8'h00;
        ew_byte     = 8'h00;
        coord_fault = 1'b0;
    endfunction

    // Advances the predicted parser by one accepted byte and queues any report it ends.
    function automatic void parse_rx_byte(input logic [7:0] b);
        fix_report_t rep;
        logic [31:0] lat_u;
        logic [31:0] lon_u;
        logic        is_digit;
        logic [7:0]  digit;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        digit    = b - CHAR_ZERO;
        if (b == CHAR_DOLLAR) begin
            forget_sentence();
            frame = FRAME_HEADER;
        end else if (frame == FRAME_HEADER) begin
            if (offset < HEADER_LEN && b == RMC_TAG[8*(HEADER_LEN-1-offset) +: 8]) begin
                offset++;
                if (offset == HEADER_LEN) begin
                    tag_done = 1'b1;
                    frame    = FRAME_BODY;
                end
            end else begin
                frame = FRAME_IDLE;
            end
        end else if (frame != FRAME_BODY || !tag_done || offset >= SENTENCE_LIMIT) begin
            frame = FRAME_IDLE;
        end else if (b == CHAR_NEWLINE) begin
            // The fix byte outranks any coordinate trouble.
            rep = '0;
            if (fix_byte != CHAR_FIX_OK) begin
                rep.status = STATUS_NO_FIX;
            end else if (coord_fault || offset <= POS_LON_LAST) begin
                rep.status = STATUS_BAD_COORD;
            end else begin
                rep.status = STATUS_OK;
                lat_u      = lat_whole * MICRO_PER_DEG + (lat_frac * 5) / 3;
                lon_u      = lon_whole * MICRO_PER_DEG + (lon_frac * 5) / 3;
                rep.lat    = lat_u[LAT_OUT_W-1:0];
                rep.lon    = lon_u[LON_OUT_W-1:0];
                rep.ns     = ns_byte;
                rep.ew     = ew_byte;
            end
            pending_reports.push_back(rep);
            reports_predicted++;
            frame = FRAME_IDLE;
        end else begin
            // Body byte: capture fields by offset, dots are never checked.
            if (offset == POS_FIX) begin
                fix_byte = b;
            end else if (offset == POS_NS) begin
                ns_byte = b;
            end else if (offset == POS_EW) begin
                ew_byte = b;
            end else if (offset >= POS_LAT_FIRST && offset <= POS_LAT_LAST &&
                         offset != POS_LAT_DOT) begin
                if (!is_digit) begin
                    coord_fault = 1'b1;
                end else if (offset < POS_LAT_MIN) begin
                    lat_whole = (lat_whole * 10 + digit) & LAT_DEG_MASK;
                end else begin
                    lat_frac = (lat_frac * 10 + digit) & MIN_MASK;
                end
            end else if (offset >= POS_LON_FIRST && offset <= POS_LON_LAST &&
                         offset != POS_LON_DOT) begin
                if (!is_digit) begin
                    coord_fault = 1'b1;
                end else if (offset < POS_LON_MIN) begin
                    lon_whole = (lon_whole * 10 + digit) & LON_DEG_MASK;
                end else begin
                    lon_frac = (lon_frac * 10 + digit) & MIN_MASK;
                end
            end
            offset++;
        end
    endfunction

    // Report checking.

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        fix_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected report, expected none, got status %0d",
                         $time, o_status);
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, o_status);
                check_field("latitude", want.lat, o_latitude_micro_deg);
                check_field("longitude", want.lon, o_longitude_micro_deg);
                check_field("north/south", want.ns, o_lat_hemisphere);
                check_field("east/west", want.ew, o_lon_hemisphere);
                reports_checked++;
            end
        end
    end

    // Report sink: shifting stall patterns, plus a long hold-off on demand.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode   = sink_mode_e'($urandom_range(0, 3));
                sink_left   = $urandom_range(16, 160);
                sink_period = $urandom_range(2, 9);
                sink_duty   = $urandom_range(1, sink_period - 1);
            end
            sink_left--;
            sink_tick++;
            case (sink_mode)
                SINK_ALWAYS: i_out_ready <= 1'b1;
                SINK_COIN:   i_out_ready <= ($urandom_range(0, 1) != 0);
                SINK_MOSTLY: i_out_ready <= ($urandom_range(0, 4) != 0);
                default:     i_out_ready <= ((sink_tick % sink_period) < sink_duty);
            endcase
        end
    end

    // Byte sending.

    // Offers one request byte and holds it until taken; sender_gaps adds random burst gaps.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                gap = $urandom_range(1, 8);
            end
        end
        burst_left--;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        parse_rx_byte(b);
    endtask

    // Sends the buffered sentence behind a dollar, optionally closed by a newline.
    task automatic send_line(input bit with_newline);
        send_byte(CHAR_DOLLAR);
        foreach (line_buf[i]) begin
            send_byte(line_buf[i]);
        end
        if (with_newline) begin
            send_byte(CHAR_NEWLINE);
        end
        framed_bytes += line_buf.size() + (with_newline ? 2 : 1);
    endtask

    // Stops offering requests until every predicted report has been taken.
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Sentence building.

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] b;
        do begin
            b = random_byte();
        end while (b >= CHAR_ZERO && b <= CHAR_NINE);
        return b;
    endfunction

    function automatic logic [7:0] random_no_fix();
        logic [7:0] b;
        do begin
            b = random_byte();
        end while (b == CHAR_FIX_OK);
        return b;
    endfunction

    // Field value biased towards its extremes.
    function automatic int unsigned pick_value(input int unsigned max_value);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return max_value;
            default: return $urandom_range(0, max_value);
        endcase
    endfunction

    function automatic void put_decimal(input int unsigned value, input int unsigned n);
        int unsigned scale;
        scale = 1;
        repeat (n - 1) scale = scale * 10;
        repeat (n) begin
            line_buf.push_back(CHAR_ZERO + 8'((value / scale) % 10));
            scale = scale / 10;
        end
    endfunction

    function automatic void trim_line(input int unsigned len);
        while (line_buf.size() > len) begin
            void'(line_buf.pop_back());
        end
    endfunction

    function automatic void pad_line(input int unsigned len);
        while (line_buf.size() < len) begin
            line_buf.push_back(8'($urandom_range(CHAR_ZERO, CH_LOWER_Z)));
        end
    endfunction

    // Lays out an RMC sentence so that each field lands on its fixed offset.
    function automatic void compose_rmc(input logic [7:0] fix, input int unsigned lat_deg,
                                        input int unsigned lat_min, input logic [7:0] ns,
                                        input int unsigned lon_deg, input int unsigned lon_min,
                                        input logic [7:0] ew, input int tail_len);
        line_buf.delete();
        for (int i = 0; i < HEADER_LEN; i++) begin
            line_buf.push_back(RMC_TAG[8*(HEADER_LEN-1-i) +: 8]);
        end
        line_buf.push_back(CH_COMMA);
        put_decimal($urandom_range(0, 235959), 6);
        line_buf.push_back(CH_DOT);
        put_decimal($urandom_range(0, 999), 3);
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(fix);
        line_buf.push_back(CH_COMMA);
        put_decimal(lat_deg, 2);
        put_decimal(lat_min / 10000, 2);
        line_buf.push_back(CH_DOT);
        put_decimal(lat_min % 10000, 4);
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(ns);
        line_buf.push_back(CH_COMMA);
        put_decimal(lon_deg, 3);
        put_decimal(lon_min / 10000, 2);
        line_buf.push_back(CH_DOT);
        put_decimal(lon_min % 10000, 4);
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(ew);
        for (int i = 0; i < tail_len; i++) begin
            line_buf.push_back(trail_text[i]);
        end
    endfunction

    // Well-formed fix with random content; now and then an odd hemisphere byte.
    function automatic void compose_random_rmc();
        logic [7:0] ns;
        logic [7:0] ew;
        ns = ($urandom_range(0, 1) != 0) ? CH_NORTH : CH_SOUTH;
        ew = ($urandom_range(0, 1) != 0) ? CH_EAST : CH_WEST;
        if ($urandom_range(0, 6) == 0) begin
            ns = random_byte();
        end
        if ($urandom_range(0, 6) == 0) begin
            ew = random_byte();
        end
        compose_rmc(CHAR_FIX_OK, pick_value(99), pick_value(999999), ns,
                    pick_value(999), pick_value(999999), ew,
                    $urandom_range(0, 6));
    endfunction

    // Tests.

    task automatic test_valid_fixes();
        compose_rmc(CHAR_FIX_OK, 0, 0, CH_NORTH, 0, 0, CH_EAST, 0);
        send_line(1'b1);
        compose_rmc(CHAR_FIX_OK, 99, 999999, CH_SOUTH, 999, 999999, CH_WEST,
                    trail_text.len());
        send_line(1'b1);
        compose_rmc(CHAR_FIX_OK, 48, 70380, CH_NORTH, 11, 310000, CH_EAST, 12);
        send_line(1'b1);
        // Newline right after the last longitude digit, no comma: complete, no east/west.
        compose_rmc(CHAR_FIX_OK, 51, 123456, CH_SOUTH, 123, 654321, CH_WEST, 0);
        trim_line(POS_LON_LAST + 1);
        send_line(1'b1);
        drain_reports();
    endtask

    task automatic test_missing_fix();
        compose_rmc(CH_VOID, 12, 345678, CH_NORTH, 98, 765432, CH_EAST, 8);
        send_line(1'b1);
        compose_rmc(random_no_fix(), 1, 1, CH_NORTH, 1, 1, CH_EAST, 3);
        send_line(1'b1);
        // Sentence ends before the fix byte ever arrives.
        compose_random_rmc();
        trim_line(POS_FIX);
        send_line(1'b1);
        // A void fix wins over a broken coordinate.
        compose_rmc(CH_VOID, 33, 0, CH_SOUTH, 44, 0, CH_WEST, 0);
        line_buf[POS_LAT_FIRST + 1] = CH_COMMA;
        send_line(1'b1);
        drain_reports();
    endtask

    task automatic test_bad_coordinates();
        compose_random_rmc();
        line_buf[POS_LAT_FIRST] = CHAR_ZERO - 8'd1;
        send_line(1'b1);
        compose_random_rmc();
        line_buf[POS_LON_LAST] = CHAR_NINE + 8'd1;
        send_line(1'b1);
        // The dot positions are not looked at.
        compose_rmc(CHAR_FIX_OK, 45, 300000, CH_NORTH, 90, 600000, CH_EAST, 5);
        line_buf[POS_LAT_DOT] = CH_FIVE;
        line_buf[POS_LON_DOT] = CH_LETTER;
        send_line(1'b1);
        // Newline on the last longitude digit leaves the longitude short.
        compose_random_rmc();
        trim_line(POS_LON_LAST);
        send_line(1'b1);
        drain_reports();
    endtask

    task automatic test_framing();
        // Bytes outside any sentence.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_NEWLINE);
        send_byte(8'h55);
        send_byte(8'hAA);
        // Wrong header letter, then a newline among the header bytes.
        compose_random_rmc();
        line_buf[HEADER_LEN - 1] = CH_BAD_TAG;
        send_line(1'b1);
        compose_random_rmc();
        trim_line(2);
        send_line(1'b1);
        // A dollar abandons the sentence in progress.
        compose_random_rmc();
        trim_line(30);
        send_line(1'b0);
        compose_random_rmc();
        send_line(1'b1);
        send_byte(CHAR_DOLLAR);
        compose_random_rmc();
        send_line(1'b1);
        drain_reports();
    endtask

    task automatic test_sentence_length();
        // Last offset that still counts, then the first one that drops the sentence.
        compose_random_rmc();
        pad_line(SENTENCE_LIMIT - 1);
        send_line(1'b1);
        compose_random_rmc();
        pad_line(SENTENCE_LIMIT);
        send_line(1'b1);
        compose_random_rmc();
        send_line(1'b1);
        drain_reports();
    endtask

    // Reports are refused for a long stretch while short sentences keep coming.
    task automatic test_output_backpressure();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (7) begin
            compose_random_rmc();
            trim_line($urandom_range(HEADER_LEN, 24));
            send_line(1'b1);
        end
        sender_gaps = 1'b1;
        drain_reports();
    endtask

    task automatic test_random_stream();
        int unsigned start_bytes;
        int unsigned start_reports;
        int unsigned roll;
        int unsigned pos;
        line_kind_e  kind;
        start_bytes   = framed_bytes;
        start_reports = reports_predicted;
        while (framed_bytes - start_bytes < RANDOM_BYTES ||
               reports_predicted - start_reports < RANDOM_REPORTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)      kind = LINE_GOOD;
            else if (roll < 60) kind = LINE_NO_FIX;
            else if (roll < 70) kind = LINE_BAD_DIGIT;
            else if (roll < 78) kind = LINE_SHORT;
            else if (roll < 82) kind = LINE_LONG;
            else if (roll < 88) kind = LINE_BAD_TAG;
            else if (roll < 94) kind = LINE_RESTART;
            else                kind = LINE_NOISE;
            compose_random_rmc();
            case (kind)
                LINE_GOOD: begin
                    send_line(1'b1);
                end
                LINE_NO_FIX: begin
                    line_buf[POS_FIX] = random_no_fix();
                    if ($urandom_range(0, 3) == 0) begin
                        line_buf[POS_LON_FIRST] = random_non_digit();
                    end
                    send_line(1'b1);
                end
                LINE_BAD_DIGIT: begin
                    pos = ($urandom_range(0, 1) != 0) ?
                          $urandom_range(POS_LAT_FIRST, POS_LAT_LAST) :
                          $urandom_range(POS_LON_FIRST, POS_LON_LAST);
                    line_buf[pos] = random_non_digit();
                    send_line(1'b1);
                end
                LINE_SHORT: begin
                    trim_line($urandom_range(HEADER_LEN, POS_EW));
                    send_line(1'b1);
                end
                LINE_LONG: begin
                    pad_line($urandom_range(SENTENCE_LIMIT - 4, SENTENCE_LIMIT + 8));
                    send_line(1'b1);
                end
                LINE_BAD_TAG: begin
                    if ($urandom_range(0, 1) != 0) begin
                        line_buf[$urandom_range(0, HEADER_LEN - 1)] = random_byte();
                    end else begin
                        trim_line($urandom_range(0, HEADER_LEN - 1));
                    end
                    send_line(1'b1);
                end
                LINE_RESTART: begin
                    trim_line($urandom_range(1, 60));
                    send_line(1'b0);
                    compose_random_rmc();
                    send_line(1'b1);
                end
                default: begin
                    repeat ($urandom_range(1, 16)) send_byte(random_byte());
                end
            endcase
            if ($urandom_range(0, 29) == 0) begin
                sender_gaps = !sender_gaps;
            end
            if ($urandom_range(0, 39) == 0) begin
                drain_reports();
            end
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        frame = FRAME_IDLE;
        forget_sentence();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_valid_fixes();
        test_missing_fix();
        test_bad_coordinates();
        test_framing();
        test_sentence_length();
        test_output_backpressure();
        test_random_stream();
        drain_reports();

        $display("Sent %0d framed bytes: valid and void fixes, bad and short coordinates,",
                 framed_bytes);
        $display("broken headers, restarts, overlong lines; %0d reports, %0d input stalls.",
                 reports_checked, input_stalls);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
